/* design/selective_repeat_send_window_unit_defines.svh */
// Assertion helpers shared by the checker.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SRSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define SRSW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

/* design/srsw_pkg.sv */
package srsw_pkg;

  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned LIMIT_W   = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 4'd8;

  // Most retransmits one tick may raise.
  localparam logic [3:0] MAX_RETX = 4'd8;

  localparam logic [7:0] ACK_KIND_VALUE = 8'd1;

  // Event kinds on mode
  localparam logic [1:0] MODE_SUBMIT = 2'd0;
  localparam logic [1:0] MODE_ACK    = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_TX_NEW      = 3'd0;
  localparam logic [2:0] ACT_RETX        = 3'd1;
  localparam logic [2:0] ACT_ACK_APPLIED = 3'd2;
  localparam logic [2:0] ACT_ACK_IGNORED = 3'd3;
  localparam logic [2:0] ACT_REJECT      = 3'd4;

  // Register index (paddr word bit)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_WINDOW  = 1'b1;

  // Command queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_SUBMIT,
    OP_ACK,
    OP_ACK_IGNORE,
    OP_TICK
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [SEQ_W-1:0] ack_seq;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       action;
    logic [SEQ_W-1:0] seq;
    logic [2:0]       slot;
    logic [SEQ_W-1:0] base;
    logic [3:0]       in_flight;
    logic [3:0]       released;
    logic             last;
  } res_t;

endpackage

/* design/selective_repeat_send_window_unit.sv */
// Sender side of a selective-repeat sliding window.
// Requests: start/busy. A request (mode, ack_seq, ack_kind) is taken on a rising
// edge with start high and busy low. Submit (mode 0), acknowledgement (mode 1)
// and tick (mode 2); mode 3 is swallowed with no result.
// Results: one cycle each on the result ports, flagged by out_valid_o; last_o
// marks the final result of a request. The receiver cannot stall, so results
// are never held back.
// Config: APB port, timeout_ticks at 0x0, window_limit at 0x4, write in idle only.
// Order: submit and ignored ack give a registered result as the request leaves
// the queue; an applied ack first releases the acknowledged front slots, then
// reports; a tick scans the slots in flight (stamp memory read, then age
// compare) and gives no result when nothing has aged.
// Throughput: one request at a time in the back end; a 2-entry request queue
// lets the sender post ahead, busy is high while that queue is full.
// Reset: window empty, base and next sequence 0, tick clock 0, timeout 200,
// window limit 8.
module selective_repeat_send_window_unit #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] ack_seq_i,
  input  logic [7:0]  ack_kind_i,
  // result channel
  output logic        out_valid_o,
  output logic [2:0]  action_o,
  output logic [31:0] seq_out_o,
  output logic [2:0]  slot_out_o,
  output logic [31:0] base_out_o,
  output logic [3:0]  in_flight_o,
  output logic [3:0]  released_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srsw_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 cfg_wr;

  cmd_t push_cmd, q_cmd;
  logic push, q_full, q_valid, q_pop;
  res_t res;

  // Registers are decoded on the word bit only.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_WINDOW) ? 32'(limit_q) : 32'(timeout_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      limit_q   <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WINDOW) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end else begin
        timeout_q <= pwdata[TIMEOUT_W-1:0];
      end
    end
  end

  // Front end: classify the request and post it.
  srsw_front u_front (
    .start      (start),
    .busy       (busy),
    .mode_i     (mode_i),
    .ack_seq_i  (ack_seq_i),
    .ack_kind_i (ack_kind_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  srsw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Back end: window state, release walk and timeout scan.
  srsw_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .timeout_i   (timeout_q),
    .limit_i     (limit_q),
    .res_o       (res)
  );

  assign out_valid_o = res.valid;
  assign action_o    = res.action;
  assign seq_out_o   = res.seq;
  assign slot_out_o  = res.slot;
  assign base_out_o  = res.base;
  assign in_flight_o = res.in_flight;
  assign released_o  = res.released;
  assign last_o      = res.last;

endmodule

/* design/srsw_front.sv */
module srsw_front (
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [31:0]        ack_seq_i,
  input  logic [7:0]         ack_kind_i,
  input  logic               q_full_i,
  output logic               push_o,
  output srsw_pkg::cmd_t     cmd_o
);
  import srsw_pkg::*;

  logic known;

  always_comb begin
    cmd_o.ack_seq = ack_seq_i;
    cmd_o.op      = OP_SUBMIT;
    known         = 1'b1;
    unique case (mode_i)
      MODE_SUBMIT: cmd_o.op = OP_SUBMIT;
      MODE_ACK: begin
        cmd_o.op = (ack_kind_i == ACK_KIND_VALUE) ? OP_ACK : OP_ACK_IGNORE;
      end
      MODE_TICK:   cmd_o.op = OP_TICK;
      default:     known = 1'b0;  // unused kind: swallowed, no result
    endcase
  end

  assign busy   = q_full_i;
  assign push_o = start && !q_full_i && known;

endmodule

/* design/srsw_queue.sv */
module srsw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srsw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output srsw_pkg::cmd_t cmd_o
);
  import srsw_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* design/srsw_back.sv */
module srsw_back #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  srsw_pkg::cmd_t                     cmd_i,
  output logic                               cmd_pop_o,
  input  logic [srsw_pkg::TIMEOUT_W-1:0]     timeout_i,
  input  logic [srsw_pkg::LIMIT_W-1:0]       limit_i,
  output srsw_pkg::res_t                     res_o
);
  import srsw_pkg::*;

  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW = IW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FLUSH
  } state_e;

  state_e            state_q;
  logic [SEQ_W-1:0]  base_q, next_q, clock_q, ack_seq_q;
  logic [IW-1:0]     head_q, slot_q;
  logic [CW-1:0]     count_q, freed_q, idx_q;
  logic [3:0]        n_q;
  logic              acked_q [WINDOW_DEPTH];
  logic              pend_valid_q;
  logic [SEQ_W-1:0]  pend_seq_q;
  logic [IW-1:0]     pend_slot_q;
  res_t              res_q;
  res_t              res_d;

  logic [SEQ_W-1:0]  stamp_mem [WINDOW_DEPTH];
  logic [SEQ_W-1:0]  stamp_rd_q;

  // Ring position of the slot at a given distance from the head.
  function automatic logic [IW-1:0] ring(input logic [IW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = {1'b0, head} + SW'(off);
    if (sum >= SW'(WINDOW_DEPTH)) begin
      sum = sum - SW'(WINDOW_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  function automatic res_t mk_res(input logic [2:0] action, input logic [SEQ_W-1:0] seq,
                                  input logic [IW-1:0] slot, input logic [SEQ_W-1:0] base,
                                  input logic [CW-1:0] cnt, input logic [CW-1:0] freed,
                                  input logic last);
    res_t r;
    r.valid     = 1'b1;
    r.action    = action;
    r.seq       = seq;
    r.slot      = 3'(slot);
    r.base      = base;
    r.in_flight = 4'(cnt);
    r.released  = 4'(freed);
    r.last      = last;
    return r;
  endfunction

  logic [7:0]        lim_eff;
  logic              sub_full;
  logic [IW-1:0]     sub_slot, ack_slot, scan_slot, head_inc;
  logic [SEQ_W-1:0]  ack_off, age;
  logic              ack_in_win, aged;
  logic [CW-1:0]     idx_nxt;
  logic [3:0]        n_nxt;
  logic              st_we;
  logic [IW-1:0]     st_waddr;

  always_comb begin
    lim_eff = 8'(limit_i);
    if (lim_eff > 8'(WINDOW_DEPTH)) begin
      lim_eff = 8'(WINDOW_DEPTH);
    end
  end

  assign sub_full   = (8'(count_q) >= lim_eff);
  assign sub_slot   = ring(head_q, count_q);
  assign ack_off    = cmd_i.ack_seq - base_q;
  assign ack_in_win = (ack_off < SEQ_W'(count_q));
  assign ack_slot   = ring(head_q, ack_off[CW-1:0]);
  assign scan_slot  = ring(head_q, idx_q);
  assign head_inc   = ring(head_q, CW'(1));
  assign age        = clock_q - stamp_rd_q;
  assign aged       = !acked_q[slot_q] && (age > SEQ_W'(timeout_i));
  assign idx_nxt    = idx_q + CW'(1);
  assign n_nxt      = n_q + 4'(aged);

  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;

  assign st_we = (cmd_pop_o && cmd_i.op == OP_SUBMIT && !sub_full) ||
                 (state_q == ST_SCAN_CMP && aged);
  assign st_waddr = (state_q == ST_IDLE) ? sub_slot : slot_q;

  // Result for this cycle; the strobe drops whenever nothing is reported.
  always_comb begin
    res_d       = res_q;
    res_d.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_SUBMIT: begin
              if (sub_full) begin
                res_d = mk_res(ACT_REJECT, next_q, '0, base_q, count_q, '0, 1'b1);
              end else begin
                res_d = mk_res(ACT_TX_NEW, next_q, sub_slot, base_q,
                               count_q + CW'(1), '0, 1'b1);
              end
            end
            OP_ACK: begin
              if (!ack_in_win) begin
                res_d = mk_res(ACT_ACK_IGNORED, cmd_i.ack_seq, '0, base_q,
                               count_q, '0, 1'b1);
              end
            end
            OP_ACK_IGNORE: begin
              res_d = mk_res(ACT_ACK_IGNORED, cmd_i.ack_seq, '0, base_q,
                             count_q, '0, 1'b1);
            end
            default: ;
          endcase
        end
      end
      ST_RELEASE: begin
        if (count_q == '0 || !acked_q[head_q]) begin
          res_d = mk_res(ACT_ACK_APPLIED, ack_seq_q, slot_q, base_q,
                         count_q, freed_q, 1'b1);
        end
      end
      ST_SCAN_CMP: begin
        if (aged && pend_valid_q) begin
          res_d = mk_res(ACT_RETX, pend_seq_q, pend_slot_q, base_q,
                         count_q, '0, 1'b0);
        end
      end
      ST_FLUSH: begin
        if (pend_valid_q) begin
          res_d = mk_res(ACT_RETX, pend_seq_q, pend_slot_q, base_q,
                         count_q, '0, 1'b1);
        end
      end
      default: ;
    endcase
  end

  // Send-time stamps; the read port runs every cycle, but only held slots are used.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stamp_mem[st_waddr] <= clock_q;
    end
    stamp_rd_q <= stamp_mem[scan_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      base_q       <= '0;
      next_q       <= '0;
      clock_q      <= '0;
      ack_seq_q    <= '0;
      head_q       <= '0;
      slot_q       <= '0;
      count_q      <= '0;
      freed_q      <= '0;
      idx_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      pend_seq_q   <= '0;
      pend_slot_q  <= '0;
      res_q        <= '0;
      for (int i = 0; i < int'(WINDOW_DEPTH); i++) begin
        acked_q[i] <= 1'b0;
      end
    end else begin
      res_q <= res_d;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_SUBMIT: begin
                if (!sub_full) begin
                  acked_q[sub_slot] <= 1'b0;
                  count_q           <= count_q + CW'(1);
                  next_q            <= next_q + SEQ_W'(1);
                end
              end
              OP_ACK: begin
                if (ack_in_win) begin
                  acked_q[ack_slot] <= 1'b1;
                  ack_seq_q         <= cmd_i.ack_seq;
                  slot_q            <= ack_slot;
                  freed_q           <= '0;
                  state_q           <= ST_RELEASE;
                end
              end
              OP_TICK: begin
                clock_q      <= clock_q + SEQ_W'(1);
                idx_q        <= '0;
                n_q          <= '0;
                pend_valid_q <= 1'b0;
                if (count_q != '0) begin
                  state_q <= ST_SCAN_RD;
                end
              end
              default: ;  // foreign header: result only
            endcase
          end
        end
        ST_RELEASE: begin
          // one front slot released per cycle
          if (count_q != '0 && acked_q[head_q]) begin
            acked_q[head_q] <= 1'b0;
            head_q          <= head_inc;
            base_q          <= base_q + SEQ_W'(1);
            count_q         <= count_q - CW'(1);
            freed_q         <= freed_q + CW'(1);
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN_RD: begin
          slot_q  <= scan_slot;
          state_q <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          // a found slot is held back one step so the final one can carry last
          if (aged) begin
            pend_valid_q <= 1'b1;
            pend_seq_q   <= base_q + SEQ_W'(idx_q);
            pend_slot_q  <= slot_q;
          end
          idx_q <= idx_nxt;
          n_q   <= n_nxt;
          if (idx_nxt >= count_q || n_nxt == MAX_RETX) begin
            state_q <= ST_FLUSH;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end
        ST_FLUSH: begin
          pend_valid_q <= 1'b0;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o = res_q;

endmodule

/* design/srsw_checker.sv */
`include "selective_repeat_send_window_unit_defines.svh"

module srsw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic [2:0] action_o,
  input logic [2:0] slot_out_o,
  input logic [3:0] released_o,
  input logic       last_o
);
  import srsw_pkg::*;

  logic refused;
  logic zeroed;
  logic single;

  assign refused = (action_o == ACT_ACK_IGNORED) || (action_o == ACT_REJECT);
  assign zeroed  = (slot_out_o == 3'd0) && (released_o == 4'd0);
  assign single  = (action_o != ACT_RETX);

  `SRSW_ASSERT_ALWAYS(a_pready_high, pready, "pready must stay high")

  `SRSW_ASSERT_IMP(a_action_known, out_valid_o, action_o <= ACT_REJECT, "undefined action code")

  `SRSW_ASSERT_IMP(a_no_slot_on_refusal, out_valid_o && refused, zeroed, "slot on refusal")

  `SRSW_ASSERT_IMP(a_single_result_last, out_valid_o && single, last_o, "result without last")

endmodule

bind selective_repeat_send_window_unit srsw_checker u_srsw_checker (.*);
